// File: rtl/rfsa_pkg.sv
package rfsa_pkg;

    // action codes of an input word
    localparam logic [1:0] ACT_PLACE   = 2'd0;
    localparam logic [1:0] ACT_READ    = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    // placement codes of a result word
    localparam logic [1:0] PLC_AFTER_HDR = 2'd0;
    localparam logic [1:0] PLC_WRAPPED   = 2'd1;
    localparam logic [1:0] PLC_GAP       = 2'd2;
    localparam logic [1:0] PLC_NONE      = 2'd3;

    // status codes
    localparam logic STS_OK       = 1'b0;
    localparam logic STS_OVERFLOW = 1'b1;

    // configuration register indexes
    localparam logic CFG_RING_START = 1'b0;
    localparam logic CFG_RING_END   = 1'b1;

    localparam int CFG_DATA_W       = 17;
    localparam logic [16:0] RING_END_RST = 17'h10000;

    // input word
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] frame_length;
        logic [15:0] new_read_offset;
    } t_in_word;

    // result word
    typedef struct packed {
        logic        status;
        logic [1:0]  placement;
        logic [15:0] header_offset;
        logic [15:0] frame_offset;
        logic [15:0] write_offset_now;
    } t_out_word;

endpackage

// File: rtl/rfsa_place.sv
module rfsa_place import rfsa_pkg::*; #(
    parameter int HEADER_BYTES = 8,
    parameter int OFFSET_BITS  = 16
) (
    input  t_in_word               i_in,
    input  logic [OFFSET_BITS-1:0] i_wr_off,
    input  logic [OFFSET_BITS-1:0] i_rd_off,
    input  logic [15:0]            i_ring_start,
    input  logic [16:0]            i_ring_end,
    output t_out_word              o_res,
    output logic                   o_wr_we,
    output logic [OFFSET_BITS-1:0] o_wr_next,
    output logic                   o_rd_we,
    output logic [OFFSET_BITS-1:0] o_rd_next
);

    // working width holds offsets, the clamped ring end and offset plus record
    localparam int CALC_W = ((OFFSET_BITS > 17) ? OFFSET_BITS : 17) + 2;
    localparam logic [CALC_W-1:0] SPAN   = CALC_W'(1) << OFFSET_BITS;
    localparam logic [CALC_W-1:0] MASK   = SPAN - CALC_W'(1);
    localparam logic [CALC_W-1:0] HB_EXT = CALC_W'(HEADER_BYTES);

    logic [CALC_W-1:0] w;
    logic [CALC_W-1:0] r;
    logic [CALC_W-1:0] start_m;
    logic [CALC_W-1:0] end_raw;
    logic [CALC_W-1:0] end_c;
    logic [CALC_W-1:0] cb;
    logic [CALC_W-1:0] need;
    logic [CALC_W-1:0] room;
    logic [CALC_W-1:0] gap;
    logic [CALC_W-1:0] w_after;
    logic [CALC_W-1:0] w_wrap;
    logic [CALC_W-1:0] w_new;
    logic [CALC_W-1:0] hdr;
    logic [CALC_W-1:0] frm;
    logic [CALC_W-1:0] rd_al;
    logic [CALC_W-1:0] w_final;
    logic              placed;
    logic [1:0]        plc;

    // operands at working width
    always_comb begin
        w       = CALC_W'(i_wr_off);
        r       = CALC_W'(i_rd_off);
        start_m = CALC_W'(i_ring_start) & MASK;
        end_raw = CALC_W'(i_ring_end);
        end_c   = (end_raw > SPAN) ? SPAN : end_raw;
        cb      = ((CALC_W'(i_in.frame_length) + CALC_W'(HEADER_BYTES - 1)) / HB_EXT)
                  * HB_EXT;
        need    = cb + HB_EXT;
        room    = (end_c > w) ? (end_c - w) : '0;
        gap     = (r > start_m) ? (r - start_m) : '0;
        w_after = w + need;
        w_wrap  = start_m + cb;
        rd_al   = ((CALC_W'(i_in.new_read_offset) / HB_EXT) * HB_EXT) & MASK;
    end

    // placement decision
    always_comb begin
        placed = 1'b0;
        plc    = PLC_NONE;
        hdr    = '0;
        frm    = '0;
        w_new  = w;
        if (r <= w) begin
            if (room >= need) begin
                placed = 1'b1;
                plc    = PLC_AFTER_HDR;
                hdr    = w;
                frm    = w + HB_EXT;
                w_new  = (w_after >= end_c) ? start_m : w_after;
            end else if (gap > cb) begin
                placed = 1'b1;
                plc    = PLC_WRAPPED;
                hdr    = w;
                frm    = start_m;
                w_new  = w_wrap;
            end
        end else if ((r - w) > need) begin
            placed = 1'b1;
            plc    = PLC_GAP;
            hdr    = w;
            frm    = w + HB_EXT;
            w_new  = w_after;
        end
    end

    // state updates and result word per action
    always_comb begin
        o_wr_we   = 1'b0;
        o_wr_next = i_wr_off;
        o_rd_we   = 1'b0;
        o_rd_next = OFFSET_BITS'(rd_al);
        o_res.status        = STS_OK;
        o_res.placement     = PLC_NONE;
        o_res.header_offset = '0;
        o_res.frame_offset  = '0;
        case (i_in.action)
            ACT_PLACE: begin
                if (placed) begin
                    o_wr_we             = 1'b1;
                    o_wr_next           = OFFSET_BITS'(w_new & MASK);
                    o_res.placement     = plc;
                    o_res.header_offset = hdr[15:0];
                    o_res.frame_offset  = frm[15:0];
                end else begin
                    o_res.status = STS_OVERFLOW;
                end
            end
            ACT_READ: begin
                o_rd_we = 1'b1;
            end
            ACT_RESTART: begin
                o_wr_we   = 1'b1;
                o_wr_next = OFFSET_BITS'(start_m);
                o_rd_we   = 1'b1;
                o_rd_next = OFFSET_BITS'(start_m);
            end
            default: begin
            end
        endcase
        w_final                = CALC_W'(o_wr_next);
        o_res.write_offset_now = w_final[15:0];
    end

endmodule

// File: rtl/ring_frame_space_allocator_top.sv
// Ring frame space allocator. Each command word (place a frame, post the
// consumer read offset, or restart both offsets at the ring start) is taken
// when i_start is high; o_busy stays low, so a word may be issued every
// cycle. The command is captured in an input register, decided by one pass
// of compares and adds, and its single result word is loaded into the result
// register at the next clock edge, flagged by o_strobe for exactly one cycle.
// Results cannot be held off, so the receiver must take every strobed word.
// Ring bounds must be written through the configuration port only while no
// command is in flight; the block itself does not enforce this.
module ring_frame_space_allocator_top import rfsa_pkg::*; #(
    parameter int HEADER_BYTES = 8,
    parameter int OFFSET_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  t_in_word              i_in,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_strobe,
    output t_out_word             o_out
);

    logic                   r_in_vld;
    t_in_word               r_in;
    logic [OFFSET_BITS-1:0] r_wr_off;
    logic [OFFSET_BITS-1:0] r_rd_off;
    logic [15:0]            r_ring_start;
    logic [16:0]            r_ring_end;
    logic                   r_out_vld;
    t_out_word              r_out;

    t_out_word              n_out;
    logic                   n_wr_we;
    logic [OFFSET_BITS-1:0] n_wr_off;
    logic                   n_rd_we;
    logic [OFFSET_BITS-1:0] n_rd_off;

    // never stalls
    assign o_busy = 1'b0;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_start <= '0;
            r_ring_end   <= RING_END_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RING_START: r_ring_start <= i_cfg_data[15:0];
                CFG_RING_END:   r_ring_end   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_start & ~o_busy;
        end
        r_in <= i_in;
    end

    // placement decision
    rfsa_place #(
        .HEADER_BYTES (HEADER_BYTES),
        .OFFSET_BITS  (OFFSET_BITS)
    ) u_place (
        .i_in         (r_in),
        .i_wr_off     (r_wr_off),
        .i_rd_off     (r_rd_off),
        .i_ring_start (r_ring_start),
        .i_ring_end   (r_ring_end),
        .o_res        (n_out),
        .o_wr_we      (n_wr_we),
        .o_wr_next    (n_wr_off),
        .o_rd_we      (n_rd_we),
        .o_rd_next    (n_rd_off)
    );

    // offset state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_off <= '0;
            r_rd_off <= '0;
        end else if (r_in_vld) begin
            if (n_wr_we) begin
                r_wr_off <= n_wr_off;
            end
            if (n_rd_we) begin
                r_rd_off <= n_rd_off;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
        r_out <= n_out;
    end

    assign o_strobe = r_out_vld;
    assign o_out    = r_out;

endmodule
